// ===== design/ipdc_pkg.sv =====
// Package for the incremental PI duty controller.
// Holds the state encoding, register indexes and arithmetic widths.
// No dependencies.
`default_nettype none

package ipdc_pkg;

    // field and register widths
    localparam int SAMPLE_W = 12;
    localparam int VREF_W   = 16;
    localparam int OFFS_W   = 12;
    localparam int GAIN_W   = 16;
    localparam int KGAIN_W  = 24;
    localparam int DUTY_W   = 25;
    localparam int PER_W    = 16;
    localparam int CMP_W    = 16;
    localparam int ERR_W    = 18;

    // streaming and register bus widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 48;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 3;

    // shift-add multiplier: radix-16 digits, LSB digit first
    localparam int ACC_W    = 44;
    localparam int DIG_W    = 4;
    localparam int CNT_W    = 3;
    localparam int NDIG_V   = 4;   // 16-bit ADC gain
    localparam int NDIG_PI  = 6;   // 24-bit PI gains
    localparam int NDIG_C   = 4;   // 16-bit PWM period

    // right-shift amounts and the rounding constant of the Q.8 shifts
    localparam int FRAC_SH  = 8;
    localparam int DUTY_SH  = 24;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

    // error saturation bounds (18-bit two's complement)
    localparam logic signed [ACC_W-1:0] ERR_HI = ACC_W'(131071);
    localparam logic signed [ACC_W-1:0] ERR_LO = -ACC_W'(131072);

    // register reset values
    localparam logic [VREF_W-1:0]  VREF_RST  = VREF_W'(12800);
    localparam logic [OFFS_W-1:0]  OFFS_RST  = OFFS_W'(432);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(1853);
    localparam logic [KGAIN_W-1:0] KP_RST    = KGAIN_W'(294822);
    localparam logic [KGAIN_W-1:0] KI_RST    = KGAIN_W'(5536);
    localparam logic [DUTY_W-1:0]  DHI_RST   = DUTY_W'(15099494);
    localparam logic [DUTY_W-1:0]  DLO_RST   = DUTY_W'(838861);
    localparam logic [PER_W-1:0]   PER_RST   = PER_W'(1250);

    // register map, word index
    typedef enum logic [IDX_W-1:0] {
        REG_VREF  = 3'd0,
        REG_OFFS  = 3'd1,
        REG_GAIN  = 3'd2,
        REG_KP    = 3'd3,
        REG_KI    = 3'd4,
        REG_DHI   = 3'd5,
        REG_DLO   = 3'd6,
        REG_PER   = 3'd7
    } t_reg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_V,
        ST_ERR,
        ST_PREP,
        ST_MUL_PI,
        ST_DUTY,
        ST_CLAMP,
        ST_MUL_C,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== design/incremental_pi_duty_controller.sv =====
// Incremental (velocity-form) PI duty controller, top level.
// Radix-16 shift-add datapath with its sequencer; depends on ipdc_pkg.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+-----------------------------------------
//  sample   | in  | s_tvalid / s_tready      | s_tdata: voltage_sample[11:0], zero pad
//  result   | out | m_tvalid / m_tready      | m_tdata: compare_value, duty_now,
//           |     |                          |   clamped_high, clamped_low, zero pad
//  config   | in  | psel/penable/pwrite, pready=1 | paddr, pwdata, prdata (8 words)
//
// One sample passes from accept to a loaded result through three multiplies on a
// single radix-16 shift-add unit, with the ERR, PREP, DUTY and CLAMP states between.
// The next sample is accepted in the cycle after the result is loaded.
// Reset is synchronous, active low: registers go to their defaults, stored duty
// and error to zero. A stalled result holds the sequencer in its final state.
`default_nettype none

module incremental_pi_duty_controller (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // sample stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [ipdc_pkg::S_DATA_W-1:0]     s_tdata,   // [11:0] voltage_sample
    // result stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [ipdc_pkg::M_DATA_W-1:0]     m_tdata,   // [15:0] compare_value,
                                                         // [40:16] duty_now,
                                                         // [41] clamped_high,
                                                         // [42] clamped_low
    // register port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [ipdc_pkg::ADDR_W-1:0]       paddr,
    input  wire  [ipdc_pkg::APB_W-1:0]        pwdata,
    output logic [ipdc_pkg::APB_W-1:0]        prdata,
    output logic                              pready
);

    localparam int ACC_W = ipdc_pkg::ACC_W;
    localparam int DIG_W = ipdc_pkg::DIG_W;

    // configuration registers
    logic [ipdc_pkg::VREF_W-1:0]  r_vref;
    logic [ipdc_pkg::OFFS_W-1:0]  r_offs;
    logic [ipdc_pkg::GAIN_W-1:0]  r_gain;
    logic [ipdc_pkg::KGAIN_W-1:0] r_kp;
    logic [ipdc_pkg::KGAIN_W-1:0] r_ki;
    logic [ipdc_pkg::DUTY_W-1:0]  r_dhi;
    logic [ipdc_pkg::DUTY_W-1:0]  r_dlo;
    logic [ipdc_pkg::PER_W-1:0]   r_per;

    // sequencer
    ipdc_pkg::t_state             r_state;
    ipdc_pkg::t_state             n_state;
    logic [ipdc_pkg::CNT_W-1:0]   r_cnt;

    // datapath
    logic [ACC_W-1:0]             r_acc;
    logic [ACC_W-1:0]             r_mc_a;
    logic [ACC_W-1:0]             r_mc_b;
    logic [ipdc_pkg::KGAIN_W-1:0] r_mp_a;
    logic [ipdc_pkg::KGAIN_W-1:0] r_mp_b;
    logic [ipdc_pkg::ERR_W-1:0]   r_err;
    logic [ipdc_pkg::ERR_W-1:0]   r_last_err;
    logic [ipdc_pkg::DUTY_W-1:0]  r_last_duty;
    logic [ipdc_pkg::DUTY_W-1:0]  r_duty;
    logic                         r_hi;
    logic                         r_lo;

    // output register
    logic                         r_m_valid;
    logic [ipdc_pkg::M_DATA_W-1:0] r_m_data;

    // control from the output decode
    logic                         w_accept;
    logic                         w_mul_step;
    logic                         w_load;
    logic                         w_last_dig;

    // combinational datapath terms
    logic [ACC_W-1:0]             w_pp_a;
    logic [ACC_W-1:0]             w_pp_b;
    logic [ACC_W-1:0]             w_rnd;
    logic [ACC_W-1:0]             w_err_full;
    logic [ipdc_pkg::ERR_W-1:0]   w_err_sat;
    logic [ipdc_pkg::DUTY_W-1:0]  w_cl_duty;
    logic                         w_cl_hi;
    logic                         w_cl_lo;
    logic [ipdc_pkg::CMP_W-1:0]   w_cmp;
    logic                         w_cfg_wr;
    ipdc_pkg::t_reg_idx           w_idx;

    // ---------------------------------------------------------------
    // register port
    assign pready   = 1'b1;
    assign w_idx    = ipdc_pkg::t_reg_idx'(paddr[ipdc_pkg::ADDR_W-1:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vref <= ipdc_pkg::VREF_RST;
            r_offs <= ipdc_pkg::OFFS_RST;
            r_gain <= ipdc_pkg::GAIN_RST;
            r_kp   <= ipdc_pkg::KP_RST;
            r_ki   <= ipdc_pkg::KI_RST;
            r_dhi  <= ipdc_pkg::DHI_RST;
            r_dlo  <= ipdc_pkg::DLO_RST;
            r_per  <= ipdc_pkg::PER_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                ipdc_pkg::REG_VREF: r_vref <= pwdata[ipdc_pkg::VREF_W-1:0];
                ipdc_pkg::REG_OFFS: r_offs <= pwdata[ipdc_pkg::OFFS_W-1:0];
                ipdc_pkg::REG_GAIN: r_gain <= pwdata[ipdc_pkg::GAIN_W-1:0];
                ipdc_pkg::REG_KP:   r_kp   <= pwdata[ipdc_pkg::KGAIN_W-1:0];
                ipdc_pkg::REG_KI:   r_ki   <= pwdata[ipdc_pkg::KGAIN_W-1:0];
                ipdc_pkg::REG_DHI:  r_dhi  <= pwdata[ipdc_pkg::DUTY_W-1:0];
                ipdc_pkg::REG_DLO:  r_dlo  <= pwdata[ipdc_pkg::DUTY_W-1:0];
                ipdc_pkg::REG_PER:  r_per  <= pwdata[ipdc_pkg::PER_W-1:0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            ipdc_pkg::REG_VREF: prdata = ipdc_pkg::APB_W'(r_vref);
            ipdc_pkg::REG_OFFS: prdata = ipdc_pkg::APB_W'(r_offs);
            ipdc_pkg::REG_GAIN: prdata = ipdc_pkg::APB_W'(r_gain);
            ipdc_pkg::REG_KP:   prdata = ipdc_pkg::APB_W'(r_kp);
            ipdc_pkg::REG_KI:   prdata = ipdc_pkg::APB_W'(r_ki);
            ipdc_pkg::REG_DHI:  prdata = ipdc_pkg::APB_W'(r_dhi);
            ipdc_pkg::REG_DLO:  prdata = ipdc_pkg::APB_W'(r_dlo);
            ipdc_pkg::REG_PER:  prdata = ipdc_pkg::APB_W'(r_per);
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ipdc_pkg::ST_IDLE:   if (s_tvalid) n_state = ipdc_pkg::ST_MUL_V;
            ipdc_pkg::ST_MUL_V:  if (w_last_dig) n_state = ipdc_pkg::ST_ERR;
            ipdc_pkg::ST_ERR:    n_state = ipdc_pkg::ST_PREP;
            ipdc_pkg::ST_PREP:   n_state = ipdc_pkg::ST_MUL_PI;
            ipdc_pkg::ST_MUL_PI: if (w_last_dig) n_state = ipdc_pkg::ST_DUTY;
            ipdc_pkg::ST_DUTY:   n_state = ipdc_pkg::ST_CLAMP;
            ipdc_pkg::ST_CLAMP:  n_state = ipdc_pkg::ST_MUL_C;
            ipdc_pkg::ST_MUL_C:  if (w_last_dig) n_state = ipdc_pkg::ST_DONE;
            ipdc_pkg::ST_DONE:   if (!r_m_valid || m_tready) n_state = ipdc_pkg::ST_IDLE;
            default:             n_state = ipdc_pkg::ST_IDLE;
        endcase
    end

    // sequencer: control outputs
    always_comb begin
        s_tready   = 1'b0;
        w_mul_step = 1'b0;
        w_load     = 1'b0;
        w_last_dig = 1'b0;
        unique case (r_state)
            ipdc_pkg::ST_IDLE:   s_tready = 1'b1;
            ipdc_pkg::ST_MUL_V: begin
                w_mul_step = 1'b1;
                w_last_dig = (r_cnt == ipdc_pkg::CNT_W'(ipdc_pkg::NDIG_V - 1));
            end
            ipdc_pkg::ST_MUL_PI: begin
                w_mul_step = 1'b1;
                w_last_dig = (r_cnt == ipdc_pkg::CNT_W'(ipdc_pkg::NDIG_PI - 1));
            end
            ipdc_pkg::ST_MUL_C: begin
                w_mul_step = 1'b1;
                w_last_dig = (r_cnt == ipdc_pkg::CNT_W'(ipdc_pkg::NDIG_C - 1));
            end
            ipdc_pkg::ST_DONE:   w_load = !r_m_valid || m_tready;
            default: ;
        endcase
    end

    assign w_accept = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipdc_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (w_mul_step && !w_last_dig) ? r_cnt + 1'b1 : '0;
        end
    end

    // ---------------------------------------------------------------
    // datapath terms
    // digit partial products, two's complement modulo the accumulator width
    assign w_pp_a = r_mc_a * ACC_W'(r_mp_a[DIG_W-1:0]);
    assign w_pp_b = r_mc_b * ACC_W'(r_mp_b[DIG_W-1:0]);

    // round to nearest, ties up, then drop 8 fraction bits
    assign w_rnd = ACC_W'($signed(r_acc + ipdc_pkg::ROUND_HALF) >>> ipdc_pkg::FRAC_SH);

    // error against reference, saturated to 18 bits
    assign w_err_full = ACC_W'(r_vref) - w_rnd;
    always_comb begin
        priority if ($signed(w_err_full) > ipdc_pkg::ERR_HI)
            w_err_sat = ipdc_pkg::ERR_HI[ipdc_pkg::ERR_W-1:0];
        else if ($signed(w_err_full) < ipdc_pkg::ERR_LO)
            w_err_sat = ipdc_pkg::ERR_LO[ipdc_pkg::ERR_W-1:0];
        else
            w_err_sat = w_err_full[ipdc_pkg::ERR_W-1:0];
    end

    // clamp of the raw duty held in the accumulator; lower limit wins
    always_comb begin
        w_cl_duty = r_acc[ipdc_pkg::DUTY_W-1:0];
        w_cl_hi   = 1'b0;
        w_cl_lo   = 1'b0;
        if ($signed(r_acc) > $signed(ACC_W'(r_dhi))) begin
            w_cl_duty = r_dhi;
            w_cl_hi   = 1'b1;
        end
        // lower check applies to the duty after the upper limit
        if (w_cl_hi ? (r_dhi < r_dlo) : ($signed(r_acc) < $signed(ACC_W'(r_dlo)))) begin
            w_cl_duty = r_dlo;
            w_cl_lo   = 1'b1;
            w_cl_hi   = 1'b0;
        end
    end

    // compare count, saturated to 16 bits
    assign w_cmp = (|r_acc[ACC_W-1:ipdc_pkg::DUTY_SH+ipdc_pkg::CMP_W]) ? '1 :
                   r_acc[ipdc_pkg::DUTY_SH+ipdc_pkg::CMP_W-1:ipdc_pkg::DUTY_SH];

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ipdc_pkg::ST_IDLE: begin
                // volts product: (sample - offset) * gain
                r_mc_a <= ACC_W'(s_tdata[ipdc_pkg::SAMPLE_W-1:0]) - ACC_W'(r_offs);
                r_mc_b <= '0;
                r_mp_a <= ipdc_pkg::KGAIN_W'(r_gain);
                r_mp_b <= '0;
                r_acc  <= '0;
            end
            ipdc_pkg::ST_MUL_V, ipdc_pkg::ST_MUL_PI, ipdc_pkg::ST_MUL_C: begin
                r_acc  <= r_acc + w_pp_a + w_pp_b;
                r_mc_a <= r_mc_a << DIG_W;
                r_mc_b <= r_mc_b << DIG_W;
                r_mp_a <= r_mp_a >> DIG_W;
                r_mp_b <= r_mp_b >> DIG_W;
            end
            ipdc_pkg::ST_ERR: begin
                r_err <= w_err_sat;
            end
            ipdc_pkg::ST_PREP: begin
                // kp * (err - last_err) + ki * err
                r_mc_a <= ACC_W'($signed(r_err)) - ACC_W'($signed(r_last_err));
                r_mc_b <= ACC_W'($signed(r_err));
                r_mp_a <= r_kp;
                r_mp_b <= r_ki;
                r_acc  <= '0;
            end
            ipdc_pkg::ST_DUTY: begin
                r_acc <= ACC_W'(r_last_duty) + w_rnd;
            end
            ipdc_pkg::ST_CLAMP: begin
                r_duty <= w_cl_duty;
                r_hi   <= w_cl_hi;
                r_lo   <= w_cl_lo;
                r_mc_a <= ACC_W'(w_cl_duty);
                r_mc_b <= '0;
                r_mp_a <= ipdc_pkg::KGAIN_W'(r_per);
                r_mp_b <= '0;
                r_acc  <= '0;
            end
            ipdc_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // loop state, updated each time a result is loaded into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_duty <= '0;
            r_last_err  <= '0;
        end else if (w_load) begin
            r_last_duty <= r_duty;
            r_last_err  <= r_err;
        end
    end

    // ---------------------------------------------------------------
    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= ipdc_pkg::M_DATA_W'({r_lo, r_hi, r_duty, w_cmp});
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // ---------------------------------------------------------------
    // assertions
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ipdc_pkg::ST_MUL_V)
        else $error("accepted sample did not start the volts multiply");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ipdc_pkg::ST_DONE && r_m_valid && !m_tready)
        |=> r_state == ipdc_pkg::ST_DONE)
        else $error("result dropped while output beat was stalled");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_m_data[ipdc_pkg::CMP_W+ipdc_pkg::DUTY_W] &&
                        r_m_data[ipdc_pkg::CMP_W+ipdc_pkg::DUTY_W+1]))
        else $error("both clamp flags set");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ipdc_pkg::CNT_W'(ipdc_pkg::NDIG_PI - 1))
        else $error("digit counter out of range");

    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_mul_step |-> ##1 r_cnt == '0)
        else $error("digit counter not cleared outside a multiply");

endmodule

`default_nettype wire

// ===== verif/duty_update_checker.sv =====
// Checker for the incremental PI duty controller: watches the sample, result and
// register channels, predicts each duty update and compares it beat by beat.
// Depends on ipdc_pkg for widths, register indexes and reset values.
`default_nettype none

module duty_update_checker
    import ipdc_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_tvalid,
    input  wire                 s_tready,
    input  wire  [S_DATA_W-1:0] s_tdata,   // [11:0] voltage_sample
    input  wire                 m_tvalid,
    input  wire                 m_tready,
    input  wire  [M_DATA_W-1:0] m_tdata,   // [15:0] compare_value, [40:16] duty_now,
                                           // [41] clamped_high, [42] clamped_low
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [ADDR_W-1:0]   paddr,
    input  wire  [APB_W-1:0]    pwdata,
    input  wire                 pready,
    output int                  o_mismatches,
    output int                  o_updates_due
);

    localparam longint ROUND_Q8  = 128;
    localparam longint ERR_POS   = 131071;
    localparam longint ERR_NEG   = -131072;
    localparam longint CMP_LIMIT = 65535;

    typedef struct packed {
        logic [CMP_W-1:0]  compare;
        logic [DUTY_W-1:0] duty;
        logic              at_upper;
        logic              at_lower;
    } pwm_update_t;

    // register copies
    logic [VREF_W-1:0]  vref;
    logic [OFFS_W-1:0]  adc_zero;
    logic [GAIN_W-1:0]  volts_per_code;
    logic [KGAIN_W-1:0] kp;
    logic [KGAIN_W-1:0] ki;
    logic [DUTY_W-1:0]  duty_max;
    logic [DUTY_W-1:0]  duty_min;
    logic [PER_W-1:0]   period;

    // loop state carried between samples
    longint held_duty  = 0;
    longint held_error = 0;

    pwm_update_t updates_due[$];
    int          mismatches = 0;

    initial begin
        o_mismatches  = 0;
        o_updates_due = 0;
    end

    // One velocity-form PI step; advances the held duty and error.
    function automatic pwm_update_t next_update(input logic [SAMPLE_W-1:0] code);
        pwm_update_t upd;
        longint      volts;
        longint      err;
        longint      step;
        longint      duty;
        longint      count;
        volts = ((longint'(code) - longint'(adc_zero)) * longint'(volts_per_code)
                 + ROUND_Q8) >>> FRAC_SH;
        err = longint'(vref) - volts;
        if (err > ERR_POS) err = ERR_POS;
        if (err < ERR_NEG) err = ERR_NEG;
        step = (longint'(kp) * (err - held_error) + longint'(ki) * err + ROUND_Q8)
               >>> FRAC_SH;
        duty = held_duty + step;
        upd.at_upper = 1'b0;
        upd.at_lower = 1'b0;
        if (duty > longint'(duty_max)) begin
            duty = longint'(duty_max);
            upd.at_upper = 1'b1;
        end
        // lower bound wins when the limits cross
        if (duty < longint'(duty_min)) begin
            duty = longint'(duty_min);
            upd.at_lower = 1'b1;
            upd.at_upper = 1'b0;
        end
        held_duty  = duty;
        held_error = err;
        count = (duty * longint'(period)) >>> DUTY_SH;
        if (count > CMP_LIMIT) count = CMP_LIMIT;
        upd.compare = count[CMP_W-1:0];
        upd.duty    = duty[DUTY_W-1:0];
        return upd;
    endfunction

    always @(posedge i_clk) begin
        pwm_update_t got;
        pwm_update_t want;
        if (!i_rst_n) begin
            vref           = VREF_RST;
            adc_zero       = OFFS_RST;
            volts_per_code = GAIN_RST;
            kp             = KP_RST;
            ki             = KI_RST;
            duty_max       = DHI_RST;
            duty_min       = DLO_RST;
            period         = PER_RST;
            held_duty      = 0;
            held_error     = 0;
            updates_due.delete();
        end else begin
            // register writes land on the access cycle
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_VREF: vref           = pwdata[VREF_W-1:0];
                    REG_OFFS: adc_zero       = pwdata[OFFS_W-1:0];
                    REG_GAIN: volts_per_code = pwdata[GAIN_W-1:0];
                    REG_KP:   kp             = pwdata[KGAIN_W-1:0];
                    REG_KI:   ki             = pwdata[KGAIN_W-1:0];
                    REG_DHI:  duty_max       = pwdata[DUTY_W-1:0];
                    REG_DLO:  duty_min       = pwdata[DUTY_W-1:0];
                    REG_PER:  period         = pwdata[PER_W-1:0];
                    default: ;
                endcase
            end

            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.compare  = m_tdata[CMP_W-1:0];
                got.duty     = m_tdata[CMP_W+DUTY_W-1:CMP_W];
                got.at_upper = m_tdata[CMP_W+DUTY_W];
                got.at_lower = m_tdata[CMP_W+DUTY_W+1];
                if (updates_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with no sample pending, compare %0d duty %0d",
                                 $time, got.compare, got.duty);
                end else begin
                    want = updates_due.pop_front();
                    if (got.compare !== want.compare || got.duty !== want.duty ||
                        got.at_upper !== want.at_upper || got.at_lower !== want.at_lower) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: duty update mismatch: compare exp %0d got %0d, ",
                                      "duty exp %0d got %0d, upper exp %0b got %0b, ",
                                      "lower exp %0b got %0b"},
                                     $time, want.compare, got.compare, want.duty, got.duty,
                                     want.at_upper, got.at_upper, want.at_lower, got.at_lower);
                    end
                end
            end

            // sample beat
            if (s_tvalid && s_tready)
                updates_due.push_back(next_update(s_tdata[SAMPLE_W-1:0]));
        end
        o_mismatches  <= mismatches;
        o_updates_due <= updates_due.size();
    end

endmodule

`default_nettype wire

// ===== verif/incremental_pi_duty_controller_test.sv =====
// Testbench top for the incremental PI duty controller: drives ADC samples and
// register writes with random idling, and gives the verdict.
// Depends on ipdc_pkg, the controller RTL and duty_update_checker.
`default_nettype none

module incremental_pi_duty_controller_test;
    import ipdc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 24;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // [11:0] voltage_sample
    logic                m_tready = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [APB_W-1:0]    pwdata   = '0;

    wire                 s_tready;
    wire                 m_tvalid;
    wire  [M_DATA_W-1:0] m_tdata;   // [15:0] compare_value, [40:16] duty_now,
                                    // [41] clamped_high, [42] clamped_low
    wire  [APB_W-1:0]    prdata;
    wire                 pready;

    int mismatches;
    int updates_due;
    int quiet_cycles = 0;
    bit tx_calm      = 1'b0;

    // copies of the registers that set the regulation point
    logic [VREF_W-1:0] sh_vref = VREF_RST;
    logic [OFFS_W-1:0] sh_offs = OFFS_RST;
    logic [GAIN_W-1:0] sh_gain = GAIN_RST;

    always #10 i_clk = ~i_clk;

    incremental_pi_duty_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    duty_update_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_updates_due(updates_due)
    );

    // Setup and access cycle; junk above the register width half the time.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value, input int width);
        logic [31:0] word;
        word = value;
        if ($urandom_range(0, 1) == 1)
            word = word | (32'($urandom()) << width);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_VREF: sh_vref = word[VREF_W-1:0];
            REG_OFFS: sh_offs = word[OFFS_W-1:0];
            REG_GAIN: sh_gain = word[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [31:0] vref, offs, gain, kp, ki, dhi, dlo, per);
        write_reg(REG_VREF, vref, VREF_W);
        write_reg(REG_OFFS, offs, OFFS_W);
        write_reg(REG_GAIN, gain, GAIN_W);
        write_reg(REG_KP,   kp,   KGAIN_W);
        write_reg(REG_KI,   ki,   KGAIN_W);
        write_reg(REG_DHI,  dhi,  DUTY_W);
        write_reg(REG_DLO,  dlo,  DUTY_W);
        write_reg(REG_PER,  per,  PER_W);
    endtask

    // Offer one sample beat after a random gap; returns on the accepting edge.
    task automatic send_sample(input logic [SAMPLE_W-1:0] code);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-SAMPLE_W){1'b0}}, code};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Mostly codes near the regulation point, so the loop stays out of the limits.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int mid;
        if (sh_gain == 0)
            mid = int'(sh_offs);
        else
            mid = int'(sh_offs) + (int'(sh_vref) * 256) / int'(sh_gain);
        mid = mid + $urandom_range(0, 40) - 20;
        if (mid > 4095) mid = 4095;
        if (mid < 0) mid = 0;
        case ($urandom_range(0, 9))
            0, 1: return SAMPLE_W'($urandom_range(0, 4095));
            2: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return sh_offs;
                    default: return SAMPLE_W'(1) << $urandom_range(0, 11);
                endcase
            end
            default: return SAMPLE_W'(mid);
        endcase
    endfunction

    task automatic run_samples(input int count);
        tx_calm = ($urandom_range(0, 3) == 0);
        repeat (count) send_sample(pick_sample());
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (updates_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic random_setup();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] lo_lim;
        logic [31:0] hi_lim;
        logic [31:0] per;
        a = $urandom_range(0, 1 << 24);
        b = $urandom_range(0, 1 << 24);
        lo_lim = (a < b) ? a : b;
        hi_lim = (a < b) ? b : a;
        if ($urandom_range(0, 4) == 0) begin
            // crossed limits
            lo_lim = hi_lim;
            hi_lim = (a < b) ? a : b;
        end
        if ($urandom_range(0, 5) == 0)
            hi_lim = $urandom_range(0, (1 << 25) - 1);
        per = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 65535);
        set_all($urandom_range(0, 65535), $urandom_range(0, 4095), $urandom_range(1, 65535),
                $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12),
                $urandom_range(0, 24'hFFFFFF) >> $urandom_range(4, 20),
                hi_lim, lo_lim, per);
    endtask

    // Result side: random stalls, calm stretches, one long hold-off under load.
    initial begin : result_sink
        int gap;
        int taken;
        bit rx_calm;
        bit held;
        taken   = 0;
        rx_calm = 1'b0;
        held    = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            gap = rx_calm ? 0 : $urandom_range(0, 11);
            if (!held && taken >= 500 && s_tvalid) begin
                gap  = 300;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            taken++;
        end
    end

    // Watchdog: too long without any beat or register access.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("incremental_pi_duty_controller_test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int edge_codes[17] = '{0, 4095, 432, 12'h555, 12'hAAA, 1, 2, 4, 8, 16, 32, 64,
                               128, 256, 512, 1024, 2048};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: full-scale codes drive the duty into both limits
        foreach (edge_codes[k]) send_sample(SAMPLE_W'(edge_codes[k]));
        run_samples(150);
        settle();

        // every register but the lower limit at its top; upper limit past one so the compare saturates
        set_all(32'hFFFF, 32'hFFF, 32'hFFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF);
        send_sample('1);
        send_sample('0);
        run_samples(120);
        settle();

        // zero gains and zero period; full-scale code saturates the error negative
        set_all(0, 0, 32'hFFFF, 0, 0, 1 << 24, 0, 0);
        send_sample('1);
        send_sample('0);
        run_samples(40);
        settle();

        // crossed limits: the lower bound wins
        set_all(VREF_RST, OFFS_RST, GAIN_RST, KP_RST, KI_RST, 0, 9000000, PER_RST);
        run_samples(60);
        settle();

        // shortest period, duty at or above one
        set_all(VREF_RST, OFFS_RST, GAIN_RST, KP_RST, KI_RST, (1 << 25) - 1, 1 << 24, 1);
        run_samples(40);
        settle();

        repeat (8) begin
            random_setup();
            run_samples(150);
            settle();
        end

        if (mismatches == 0 && updates_due == 0)
            $display("incremental_pi_duty_controller_test passed");
        else
            $display("incremental_pi_duty_controller_test failed");
        $finish;
    end

endmodule

`default_nettype wire
